// File: sv/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// No dependencies; used by every module of the block.
package bba_pkg;

   // Default sizes
   localparam int NUM_BLOCKS_DEF  = 1024;
   localparam int MAX_RESERVE_DEF = 16;

   // Block number width, bitmap word width and bit-in-word width
   localparam int PTR_W  = 10;
   localparam int WORD_W = 32;
   localparam int WB     = 5;

   // Request kinds
   localparam logic [1:0] KIND_RESERVE   = 2'd0;
   localparam logic [1:0] KIND_MARK_USED = 2'd1;
   localparam logic [1:0] KIND_MARK_FREE = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_RANGE    = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  reserve_count;
      logic [10:0] target_block;
   } req_type;

   typedef struct packed {
      logic [9:0] found_block;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      CLEAR,
      IDLE,
      SEEK_RD,
      SEEK_EV,
      RESULT,
      EMIT_RD,
      EMIT_LD
   } state_type;

   // Bitmap memory controls
   typedef struct packed {
      logic rd_en;
      logic bit_we;
      logic bit_val;
      logic clr_we;
   } bm_cmd_type;

   // Found list memory controls
   typedef struct packed {
      logic we;
      logic rd_en;
   } list_cmd_type;

   // Outcome of scanning one bitmap word
   typedef struct packed {
      logic             hit;
      logic             at_end;
      logic [PTR_W-1:0] pos;
   } seek_res_type;

endpackage

// File: sv/bba_bitmap_ram.sv
// Usage bitmap storage: words of WORD_W bits, one bit per block.
// Depends on bba_pkg. Bit write, whole-word clear, registered read.
module bba_bitmap_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                       clock,
   input  bba_pkg::bm_cmd_type        cmd,
   input  logic [AW-1:0]              wr_addr,
   input  logic [bba_pkg::WB-1:0]     wr_bit,
   input  logic [AW-1:0]              rd_addr,
   output logic [bba_pkg::WORD_W-1:0] rd_data
);

   logic [bba_pkg::WORD_W-1:0] mem [DEPTH];
   logic [bba_pkg::WORD_W-1:0] rd_data_ff;

   // Write port: clearing pass or single-bit update
   always_ff @(posedge clock) begin
      if (cmd.clr_we) begin
         mem[wr_addr] <= '0;
      end else if (cmd.bit_we) begin
         mem[wr_addr][wr_bit] <= cmd.bit_val;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/bba_list_ram.sv
// Found-block list: block numbers found by the current reserve transaction.
// Depends on bba_pkg. One write port, one registered read port.
module bba_list_ram #(
   parameter int DEPTH = 16,
   parameter int LW    = 4
) (
   input  logic                      clock,
   input  bba_pkg::list_cmd_type     cmd,
   input  logic [LW-1:0]             wr_addr,
   input  logic [bba_pkg::PTR_W-1:0] wr_data,
   input  logic [LW-1:0]             rd_addr,
   output logic [bba_pkg::PTR_W-1:0] rd_data
);

   logic [bba_pkg::PTR_W-1:0] mem [DEPTH];
   logic [bba_pkg::PTR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/bba_seek.sv
// Word scanner: first free block in one bitmap word within the search window.
// Depends on bba_pkg. Window is [scan, hi], block 0 always excluded.
module bba_seek (
   input  logic [bba_pkg::WORD_W-1:0] word,
   input  logic [bba_pkg::PTR_W-1:0]  scan,
   input  logic [bba_pkg::PTR_W-1:0]  hi,
   output bba_pkg::seek_res_type      res
);

   // Lowest candidate bit wins; flag a word that reaches the end of the window
   always_comb begin
      logic [bba_pkg::PTR_W-1:0] g;
      res.hit    = 1'b0;
      res.pos    = '0;
      res.at_end =
         ({scan[bba_pkg::PTR_W-1:bba_pkg::WB], {bba_pkg::WB{1'b1}}} >= hi);
      for (int j = bba_pkg::WORD_W - 1; j >= 0; j--) begin
         g = {scan[bba_pkg::PTR_W-1:bba_pkg::WB], bba_pkg::WB'(j)};
         if (!word[j] && (bba_pkg::WB'(j) >= scan[bba_pkg::WB-1:0]) &&
             (g <= hi) && (g != '0)) begin
            res.hit = 1'b1;
            res.pos = g;
         end
      end
   end

endmodule

// File: sv/bitmap_block_allocator.sv
// Next-fit bitmap block allocator, one transaction in flight. Mark: the accepted request
// goes to RESULT, which registers the result once the output is free. Reserve of N: each
// bitmap word is read, then evaluated (the word is read again after each block found),
// then each result is read back from the found list and loaded into the output register;
// result stalls hold RESULT and EMIT_LD until the output is free.
// Reset: clearing pass writes every bitmap word to zero, req_stall high.
module bitmap_block_allocator #(
   parameter int NUM_BLOCKS  = bba_pkg::NUM_BLOCKS_DEF,
   parameter int MAX_RESERVE = bba_pkg::MAX_RESERVE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bba_pkg::rsp_type rsp_data
);

   localparam int PW    = bba_pkg::PTR_W;
   localparam int DEPTH = (NUM_BLOCKS + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW    = (MAX_RESERVE > 1) ? $clog2(MAX_RESERVE) : 1;
   localparam int CW    = $clog2(MAX_RESERVE + 1);
   localparam int SPAN  = (NUM_BLOCKS < (2 ** PW)) ? NUM_BLOCKS : (2 ** PW);
   localparam logic [PW-1:0] LAST_POS = PW'(SPAN - 1);
   localparam int BA    = PW - bba_pkg::WB;

   // Pointer advance with wrap
   function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
      logic [PW:0] inc;
      inc = {1'b0, p} + (PW + 1)'(1);
      return (int'(inc) >= SPAN) ? '0 : inc[PW-1:0];
   endfunction

   bba_pkg::state_type state_ff, state_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic [PW-1:0]      ptr_ff, ptr_in;
   logic [PW-1:0]      saved_ff, saved_in;
   logic [PW-1:0]      scan_ff, scan_in;
   logic               wrap_ff, wrap_in;
   logic [PW-1:0]      first_ff, first_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      emit_ff, emit_in;
   logic [1:0]         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bba_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                       acc;
   logic                       out_free;
   logic                       out_rdy;
   logic                       range_err;
   logic                       clr_done;
   logic [PW-1:0]              hi;
   logic [PW-1:0]              np_start;
   logic [PW-1:0]              np_hit;
   logic                       seek_fail;
   logic                       seek_done;
   logic                       emit_last;
   logic [bba_pkg::WORD_W-1:0] bm_word;
   logic [PW-1:0]              list_q;
   bba_pkg::bm_cmd_type        bm_cmd;
   bba_pkg::list_cmd_type      list_cmd;
   bba_pkg::seek_res_type      sres;
   logic [AW-1:0]              bm_wr_addr;
   logic [AW-1:0]              bm_rd_addr;

   // Handshake
   assign req_stall = (state_ff != bba_pkg::IDLE);
   assign acc       = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Decode helpers
   assign range_err = (int'(req_data.target_block) >= NUM_BLOCKS);
   assign clr_done  = (clr_addr_ff == AW'(DEPTH - 1));
   assign hi        = wrap_ff ? ptr_ff : LAST_POS;
   assign np_start  = next_pos(ptr_ff);
   assign np_hit    = next_pos(sres.pos);
   assign seek_fail = sres.hit ? ((idx_ff != '0) && (sres.pos == first_ff))
                               : (sres.at_end && wrap_ff);
   assign seek_done = sres.hit && !seek_fail && ((idx_ff + CW'(1)) == cnt_ff);
   assign emit_last = ((emit_ff + CW'(1)) == cnt_ff);
   assign out_rdy   = out_free;

   // Memories and scanner
   assign bm_wr_addr = (state_ff == bba_pkg::CLEAR) ? clr_addr_ff
                     : AW'(32'(req_data.target_block) >> bba_pkg::WB);
   assign bm_rd_addr = AW'(scan_ff[PW-1:bba_pkg::WB]);

   always_comb begin
      bm_cmd.clr_we  = (state_ff == bba_pkg::CLEAR);
      bm_cmd.rd_en   = (state_ff == bba_pkg::SEEK_RD);
      bm_cmd.bit_we  = acc && !range_err &&
                       (req_data.kind inside {bba_pkg::KIND_MARK_USED,
                                              bba_pkg::KIND_MARK_FREE});
      bm_cmd.bit_val = (req_data.kind == bba_pkg::KIND_MARK_USED);
      list_cmd.we    = (state_ff == bba_pkg::SEEK_EV) && sres.hit && !seek_fail;
      list_cmd.rd_en = (state_ff == bba_pkg::EMIT_RD);
   end

   bba_bitmap_ram #(.DEPTH(DEPTH), .AW(AW)) u_bitmap (
      .clock   (clock),
      .cmd     (bm_cmd),
      .wr_addr (bm_wr_addr),
      .wr_bit  (req_data.target_block[bba_pkg::WB-1:0]),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_word)
   );

   bba_list_ram #(.DEPTH(MAX_RESERVE), .LW(LW)) u_list (
      .clock   (clock),
      .cmd     (list_cmd),
      .wr_addr (LW'(idx_ff)),
      .wr_data (sres.pos),
      .rd_addr (LW'(emit_ff)),
      .rd_data (list_q)
   );

   bba_seek u_seek (
      .word (bm_word),
      .scan (scan_ff),
      .hi   (hi),
      .res  (sres)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bba_pkg::CLEAR: begin
            if (clr_done) state_in = bba_pkg::IDLE;
         end
         bba_pkg::IDLE: begin
            if (acc) begin
               unique case (req_data.kind) inside
                  bba_pkg::KIND_RESERVE: begin
                     if (req_data.reserve_count != '0) state_in = bba_pkg::SEEK_RD;
                  end
                  bba_pkg::KIND_MARK_USED, bba_pkg::KIND_MARK_FREE: begin
                     state_in = bba_pkg::RESULT;
                  end
                  default: state_in = bba_pkg::IDLE;
               endcase
            end
         end
         bba_pkg::SEEK_RD: state_in = bba_pkg::SEEK_EV;
         bba_pkg::SEEK_EV: begin
            if (seek_fail)      state_in = bba_pkg::RESULT;
            else if (seek_done) state_in = bba_pkg::EMIT_RD;
            else                state_in = bba_pkg::SEEK_RD;
         end
         bba_pkg::RESULT: begin
            if (out_rdy) state_in = bba_pkg::IDLE;
         end
         bba_pkg::EMIT_RD: state_in = bba_pkg::EMIT_LD;
         bba_pkg::EMIT_LD: begin
            if (out_rdy) state_in = emit_last ? bba_pkg::IDLE : bba_pkg::EMIT_RD;
         end
         default: state_in = bba_pkg::IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      clr_addr_in  = clr_addr_ff;
      ptr_in       = ptr_ff;
      saved_in     = saved_ff;
      scan_in      = scan_ff;
      wrap_in      = wrap_ff;
      first_in     = first_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      emit_in      = emit_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         bba_pkg::CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         bba_pkg::IDLE: begin
            // Reserve setup: save pointer, start just past it
            saved_in  = ptr_ff;
            scan_in   = np_start;
            wrap_in   = (np_start == '0);
            idx_in    = '0;
            cnt_in    = (int'(req_data.reserve_count) > MAX_RESERVE) ? CW'(MAX_RESERVE)
                                                                   : CW'(req_data.reserve_count);
            status_in = range_err ? bba_pkg::ST_RANGE : bba_pkg::ST_OK;
         end
         bba_pkg::SEEK_RD: begin
         end
         bba_pkg::SEEK_EV: begin
            if (seek_fail) begin
               ptr_in    = saved_ff;
               status_in = bba_pkg::ST_NO_SPACE;
            end else if (sres.hit) begin
               if (idx_ff == '0) first_in = sres.pos;
               ptr_in  = sres.pos;
               idx_in  = idx_ff + CW'(1);
               scan_in = np_hit;
               wrap_in = (np_hit == '0);
               emit_in = '0;
            end else if (sres.at_end) begin
               // Wrap around to the start of the bitmap
               scan_in = '0;
               wrap_in = 1'b1;
            end else begin
               scan_in = {scan_ff[PW-1:bba_pkg::WB] + BA'(1), bba_pkg::WB'(0)};
            end
         end
         bba_pkg::RESULT: begin
            if (out_rdy) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.found_block = '0;
               rsp_data_in.status      = status_ff;
               rsp_data_in.last        = 1'b1;
            end
         end
         bba_pkg::EMIT_RD: begin
         end
         bba_pkg::EMIT_LD: begin
            if (out_rdy) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.found_block = list_q;
               rsp_data_in.status      = bba_pkg::ST_OK;
               rsp_data_in.last        = emit_last;
               emit_in                 = emit_ff + CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bba_pkg::CLEAR;
         clr_addr_ff  <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      saved_ff    <= saved_in;
      scan_ff     <= scan_in;
      wrap_ff     <= wrap_in;
      first_ff    <= first_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      emit_ff     <= emit_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Checks
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bba_pkg::CLEAR) |-> req_stall)
      else $error("request accepted during bitmap clear");

   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status != bba_pkg::ST_OK)) |->
      (rsp_data_ff.last && (rsp_data_ff.found_block == '0)))
      else $error("error result not final or carries a block");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bba_pkg::SEEK_EV) |-> (idx_ff < cnt_ff))
      else $error("found count overran request count");

   a_ptr_restore: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == bba_pkg::SEEK_EV) && seek_fail) |=> (ptr_ff == $past(saved_ff)))
      else $error("pointer not restored after failed reserve");

endmodule
